[rtl/core/thermocycle_pid_controller_assert.svh]
// Assertion macros shared by the thermocycle PID controller RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef THERMOCYCLE_PID_CONTROLLER_ASSERT_SVH
`define THERMOCYCLE_PID_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TCPID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tcpid assertion failed");
// next-cycle implication
`define TCPID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tcpid assertion failed");
`else
`define TCPID_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TCPID_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/tcpid_pkg.sv]
// Package for the thermocycle PID controller: field widths, register
// indexes, fixed-point constants and the structs passed between modules.
package tcpid_pkg;

    localparam int TEMP_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int TOTAL_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int INTEG_W     = 22;
    localparam int LEVEL_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_DATA_W  = 24;

    // one degree in 1/64 degree units
    localparam logic signed [TEMP_W:0] ONE_DEGREE = 17'sd64;
    // integral ceiling: 255 output steps in 2^-14 units
    localparam logic [INTEG_W-1:0] INTEG_MAX = 22'd4177920;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_UPPER_TARGET = 3'd3,
        CFG_LOWER_TARGET = 3'd4,
        CFG_TOTAL_CYCLES = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0]  prop_gain;
        logic        [GAIN_W-1:0]  integ_gain;
        logic        [GAIN_W-1:0]  deriv_gain;
        logic signed [TEMP_W-1:0]  upper_target;
        logic signed [TEMP_W-1:0]  lower_target;
        logic        [TOTAL_W-1:0] total_cycles;
    } t_cfg;

    typedef struct packed {
        logic               finished;
        logic [COUNT_W-1:0] cycles_done;
        logic               cooling_phase;
        logic               fan_on;
        logic [LEVEL_W-1:0] led_level;
    } t_result;

endpackage

[rtl/core/tcpid_cfg.sv]
// Configuration register file of the thermocycle PID controller.
// Depends on tcpid_pkg for register indexes and the t_cfg struct.
module tcpid_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [tcpid_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [tcpid_pkg::CFG_DATA_W-1:0]    i_data,
    output tcpid_pkg::t_cfg                     o_cfg
);
    import tcpid_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (t_cfg_idx'(i_index))
                CFG_PROP_GAIN:    n_cfg.prop_gain    = i_data;
                CFG_INTEG_GAIN:   n_cfg.integ_gain   = i_data;
                CFG_DERIV_GAIN:   n_cfg.deriv_gain   = i_data;
                CFG_UPPER_TARGET: n_cfg.upper_target = $signed(i_data);
                CFG_LOWER_TARGET: n_cfg.lower_target = $signed(i_data);
                CFG_TOTAL_CYCLES: n_cfg.total_cycles = i_data[TOTAL_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= 16'd256;
            r_cfg.integ_gain   <= 16'd0;
            r_cfg.deriv_gain   <= 16'd0;
            r_cfg.upper_target <= 16'sd6080;
            r_cfg.lower_target <= 16'sd3840;
            r_cfg.total_cycles <= 10'd30;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/tcpid_datapath.sv]
// Controller state and single-pass PID update for one temperature sample.
// Depends on tcpid_pkg and thermocycle_pid_controller_assert.svh.
`include "thermocycle_pid_controller_assert.svh"
module tcpid_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcpid_pkg::t_cfg                     i_cfg,
    input  logic                                i_step,
    input  logic signed [tcpid_pkg::TEMP_W-1:0] i_temperature,
    output tcpid_pkg::t_result                  o_result
);
    import tcpid_pkg::*;

    logic                      r_phase,    n_phase;
    logic                      r_fan,      n_fan;
    logic [COUNT_W-1:0]        r_count,    n_count;
    logic [INTEG_W-1:0]        r_integral, n_integral;
    logic signed [TEMP_W-1:0]  r_prev,     n_prev;
    logic [LEVEL_W-1:0]        r_level,    n_level;

    logic                      held;
    logic signed [TEMP_W:0]    temp_x;
    logic signed [TEMP_W:0]    hi_thresh;
    logic signed [TEMP_W:0]    lo_thresh;
    logic                      to_cool;
    logic                      to_heat;
    logic                      phase_c;
    logic signed [TEMP_W:0]    target_x;
    logic signed [TEMP_W:0]    err;
    logic signed [TEMP_W:0]    dmeas;
    logic signed [33:0]        iprod;
    logic signed [33:0]        pprod;
    logic signed [33:0]        dprod;
    logic signed [34:0]        isum;
    logic [INTEG_W-1:0]        integ_c;
    logic signed [36:0]        sum;
    logic [LEVEL_W-1:0]        level_c;

    // phase switching against the thresholds one degree inside the targets
    always_comb begin
        held      = r_count > {1'b0, i_cfg.total_cycles};
        temp_x    = {i_temperature[TEMP_W-1], i_temperature};
        hi_thresh = {i_cfg.upper_target[TEMP_W-1], i_cfg.upper_target} - ONE_DEGREE;
        lo_thresh = {i_cfg.lower_target[TEMP_W-1], i_cfg.lower_target} + ONE_DEGREE;
        to_cool   = !r_phase && (temp_x >= hi_thresh);
        to_heat   = r_phase && (temp_x <= lo_thresh);
        phase_c   = to_cool ? 1'b1 : (to_heat ? 1'b0 : r_phase);
        target_x  = phase_c ? {i_cfg.lower_target[TEMP_W-1], i_cfg.lower_target}
                            : {i_cfg.upper_target[TEMP_W-1], i_cfg.upper_target};
        err       = target_x - temp_x;
        dmeas     = temp_x - {r_prev[TEMP_W-1], r_prev};
    end

    // three gain products, all in 2^-14 output steps
    always_comb begin
        iprod = $signed({1'b0, i_cfg.integ_gain}) * err;
        pprod = $signed({1'b0, i_cfg.prop_gain}) * err;
        dprod = $signed({1'b0, i_cfg.deriv_gain}) * dmeas;
    end

    // integral accumulate with anti-windup clamp
    always_comb begin
        isum = $signed({13'd0, r_integral}) + {iprod[33], iprod};
        if (isum[34]) begin
            integ_c = '0;
        end else if (isum[33:0] > {12'd0, INTEG_MAX}) begin
            integ_c = INTEG_MAX;
        end else begin
            integ_c = isum[INTEG_W-1:0];
        end
    end

    // PID sum, truncate toward zero and clamp to the level range
    always_comb begin
        sum = {{3{pprod[33]}}, pprod} + $signed({15'd0, integ_c})
            - {{3{dprod[33]}}, dprod};
        if (sum[36] || (sum == '0)) begin
            level_c = '0;
        end else if (|sum[35:22]) begin
            level_c = '1;
        end else begin
            level_c = sum[21:14];
        end
    end

    // state update; a held controller keeps everything
    always_comb begin
        n_phase    = r_phase;
        n_fan      = r_fan;
        n_count    = r_count;
        n_integral = r_integral;
        n_prev     = r_prev;
        n_level    = r_level;
        if (i_step && !held) begin
            n_phase    = phase_c;
            n_fan      = phase_c;
            n_count    = to_heat ? r_count + 11'd1 : r_count;
            n_integral = integ_c;
            n_prev     = i_temperature;
            n_level    = level_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 1'b0;
            r_fan      <= 1'b0;
            r_count    <= '0;
            r_integral <= '0;
            r_prev     <= '0;
            r_level    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_fan      <= n_fan;
            r_count    <= n_count;
            r_integral <= n_integral;
            r_prev     <= n_prev;
            r_level    <= n_level;
        end
    end

    // result of this step, taken by the output register
    always_comb begin
        o_result.led_level     = n_level;
        o_result.fan_on        = n_fan;
        o_result.cooling_phase = n_phase;
        o_result.cycles_done   = n_count;
        o_result.finished      = n_count > {1'b0, i_cfg.total_cycles};
    end

    `TCPID_ASSERT_IMP(a_integ_bound, i_clk, i_rst_n, 1'b1, r_integral <= INTEG_MAX)
    `TCPID_ASSERT_IMP(a_fan_tracks_phase, i_clk, i_rst_n, 1'b1, r_fan == r_phase)
    `TCPID_ASSERT_NXT(a_idle_keeps_state, i_clk, i_rst_n, !i_step,
        $stable(r_count) && $stable(r_integral) && $stable(r_prev))
    `TCPID_ASSERT_NXT(a_held_keeps_state, i_clk, i_rst_n, i_step && held,
        $stable(r_count) && $stable(r_level) && $stable(r_phase))
    `TCPID_ASSERT_NXT(a_count_on_heat, i_clk, i_rst_n, i_step && !held && to_heat,
        r_count == $past(r_count) + 11'd1)

endmodule

[rtl/core/thermocycle_pid_controller.sv]
// Thermal cycling PID controller with anti-windup.
// Interfaces: a sample stream (i_s_*), a result stream (o_m_*) and a config
// write channel (i_cfg_*). Result tdata bits, low to high: led_level[7:0],
// fan_on[8], cooling_phase[9], cycles_done[20:10], finished[21], zero pad.
// Each accepted temperature sample gives one result: the sample waits in the
// input register, then the PID update loads the result register. One sample
// per cycle is sustained while the receiver takes results; the update path
// (three 17x17 products, integral clamp, sum and level clamp) is one
// combinational pass between the state registers, since each sample needs
// the integral and phase left by the previous one.
// Reset (i_rst_n low, synchronous) starts heating with count, integral,
// previous sample and drive at zero and loads the default gains/targets.
// If the receiver stalls, the result register holds its transaction; the
// input register still takes one more sample, then o_s_tready drops.
// Config writes are always ready and must only occur while the block is
// idle. Depends on tcpid_pkg, tcpid_cfg and tcpid_datapath.
module thermocycle_pid_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample stream; tdata: temperature[15:0]
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [tcpid_pkg::TEMP_W-1:0]         i_s_tdata,
    // result stream; tdata: led_level, fan_on, cooling_phase, cycles_done,
    // finished, pad
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [tcpid_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tcpid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tcpid_pkg::*;

    t_cfg               cfg;
    t_result            step_result;
    logic               advance;
    logic               step;

    logic               r_in_valid;
    logic               n_in_valid;
    logic [TEMP_W-1:0]  r_temp;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_result;

    assign o_cfg_ready = 1'b1;

    tcpid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // pipeline control: the update runs when the result slot frees up
    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    always_comb begin
        n_in_valid  = (i_s_tvalid && o_s_tready) ? 1'b1 : (step ? 1'b0 : r_in_valid);
        n_out_valid = advance ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input sample register
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_temp <= i_s_tdata;
        end
    end

    tcpid_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step        (step),
        .i_temperature ($signed(r_temp)),
        .o_result      (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_result.finished, r_result.cycles_done,
                         r_result.cooling_phase, r_result.fan_on, r_result.led_level};

endmodule
